// ===== rtl/core/ptz_pkg.sv =====
package ptz_pkg;

  localparam int FRAME_W = 13;
  localparam int DIST_W = 16;
  localparam int ANGLE_W = 16;
  localparam int ZOOM_W = 16;
  localparam int POS_W = 12;
  localparam int ANGLE_FRAC_BITS_DEF = 14;
  localparam int ZOOM_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STEPS = 28;
  localparam int CV_W = 34;
  localparam int CZ_W = 31;
  localparam int FRAME_MAX = 4096;
  localparam logic [CZ_W-1:0] HALF_PI_Q28 = 31'd421657428;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DISTANCE = 2'd2;

  function automatic logic [CZ_W-1:0] atan_q28(input int i);
    logic [CZ_W-1:0] t;
    case (i)
      0: t = 31'd210828714;
      1: t = 31'd124459457;
      2: t = 31'd65760959;
      3: t = 31'd33381290;
      4: t = 31'd16755422;
      5: t = 31'd8385879;
      6: t = 31'd4193963;
      7: t = 31'd2097109;
      8: t = 31'd1048571;
      9: t = 31'd524287;
      default: t = CZ_W'(32'd1 << (28 - i));
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/ptz_stream_if.sv =====
interface ptz_stream_if #(
  parameter int W = 1
);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ptz_crop_window.sv =====
// An input transfer passes through the zoom divider, the 28-step CORDIC,
// the product stage, the 48-bit offset divider and the output register in series.
// Throughput: one request per cycle while the output is not stalled; every stage
// advances together whenever the output register is empty or being taken, so a
// stall freezes the whole pipeline.
// Reset (synchronous, active high) clears all valid bits and loads 1920 x 1080 / 1000.
module ptz_crop_window #(
  parameter int ANGLE_FRAC_BITS = ptz_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int ZOOM_FRAC_BITS = ptz_pkg::ZOOM_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ptz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptz_pkg::DIST_W-1:0] cfg_data,
  ptz_stream_if.sink req,
  ptz_stream_if.source rsp
);
  import ptz_pkg::*;

  // Request payload is {pan_angle, tilt_angle, zoom_factor}; response payload is
  // {crop_left, crop_top, crop_width, crop_height}.
  localparam int ZNUM_W = FRAME_W + ZOOM_FRAC_BITS;
  localparam int ONUM_W = 48;
  localparam int OFF_W = 12;

  logic [FRAME_W-1:0] frame_width;
  logic [FRAME_W-1:0] frame_height;
  logic [DIST_W-1:0] view_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_W'(1920);
      frame_height <= FRAME_W'(1080);
      view_distance <= DIST_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: frame_width <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_W-1:0];
        REG_VIEW_DISTANCE: view_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective settings: frame sizes saturated into 1..4096, distance at least 1.
  logic [FRAME_W-1:0] w_eff, h_eff;
  logic [DIST_W-1:0] d_eff;
  assign w_eff = (frame_width == '0) ? FRAME_W'(1) :
                 (frame_width > FRAME_W'(FRAME_MAX)) ? FRAME_W'(FRAME_MAX) : frame_width;
  assign h_eff = (frame_height == '0) ? FRAME_W'(1) :
                 (frame_height > FRAME_W'(FRAME_MAX)) ? FRAME_W'(FRAME_MAX) : frame_height;
  assign d_eff = (view_distance == '0) ? DIST_W'(1) : view_distance;

  // The whole pipeline moves when the output register can take a new value.
  logic out_valid;
  logic adv;
  assign adv = !out_valid || rsp.ready;
  assign req.ready = adv;

  logic acc;
  assign acc = req.valid && req.ready;

  logic [ANGLE_W-1:0] in_pan, in_tilt;
  logic [ZOOM_W-1:0] in_zoom, z_eff;
  assign in_pan = req.data[3*ANGLE_W-1 -: ANGLE_W];
  assign in_tilt = req.data[2*ANGLE_W-1 -: ANGLE_W];
  assign in_zoom = req.data[ZOOM_W-1:0];
  assign z_eff = (in_zoom < ZOOM_W'(1 << ZOOM_FRAC_BITS)) ?
                 ZOOM_W'(1 << ZOOM_FRAC_BITS) : in_zoom;

  // Stage A: crop size divisions, angles ride along as tags.
  localparam int ZTAG_W = ANGLE_W;
  logic zw_v, zh_v;
  logic [ZNUM_W-1:0] cw_q, ch_q;
  logic [ZTAG_W-1:0] zw_tag, zh_tag;

  ptz_divider #(.NUM_W(ZNUM_W), .DEN_W(ZOOM_W), .TAG_W(ZTAG_W)) u_div_w (
    .clk, .rst, .adv,
    .in_valid(acc),
    .in_num({w_eff, ZOOM_FRAC_BITS'(0)}),
    .in_den(z_eff),
    .in_tag(in_pan),
    .out_valid(zw_v),
    .out_quo(cw_q),
    .out_tag(zw_tag)
  );

  ptz_divider #(.NUM_W(ZNUM_W), .DEN_W(ZOOM_W), .TAG_W(ZTAG_W)) u_div_h (
    .clk, .rst, .adv,
    .in_valid(acc),
    .in_num({h_eff, ZOOM_FRAC_BITS'(0)}),
    .in_den(z_eff),
    .in_tag(in_tilt),
    .out_valid(zh_v),
    .out_quo(ch_q),
    .out_tag(zh_tag)
  );

  // Frame sizes are not carried with the item; the user must keep configuration static
  // while busy (not enforced by the block): later stages read the registers directly.
  logic [FRAME_W-1:0] cw, ch;
  assign cw = (cw_q == '0) ? FRAME_W'(1) : cw_q[FRAME_W-1:0];
  assign ch = (ch_q == '0) ? FRAME_W'(1) : ch_q[FRAME_W-1:0];

  // Angle magnitude to Q.28; the sign is kept separately in the neg field.
  function automatic logic [CZ_W-1:0] to_q28(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] m;
    logic [CZ_W+ANGLE_W-1:0] s;
    m = a[ANGLE_W-1] ? (~a + 1'b1) : a;
    s = {{CZ_W{1'b0}}, m} << (28 - ANGLE_FRAC_BITS);
    if (s >= (CZ_W+ANGLE_W)'(HALF_PI_Q28)) begin
      return {CZ_W{1'b1}};
    end
    return s[CZ_W-1:0];
  endfunction

  typedef struct packed {
    logic neg;
    logic sat;
    logic [FRAME_W-1:0] range;
    logic [FRAME_W-1:0] crop;
  } axis_t;

  localparam int AX_W = $bits(axis_t);

  axis_t ax_w, ax_h;
  logic [CZ_W-1:0] qw, qh;
  logic [ANGLE_W-1:0] pan_a, tilt_a;
  assign pan_a = zw_tag;
  assign tilt_a = zh_tag;

  always_comb begin
    qw = to_q28(pan_a);
    qh = to_q28(tilt_a);
    ax_w.neg = pan_a[ANGLE_W-1];
    ax_w.sat = (qw == {CZ_W{1'b1}});
    ax_w.range = (w_eff - cw) >> 1;
    ax_w.crop = cw;
    ax_h.neg = tilt_a[ANGLE_W-1];
    ax_h.sat = (qh == {CZ_W{1'b1}});
    ax_h.range = (h_eff - ch) >> 1;
    ax_h.crop = ch;
  end

  // Stage B: CORDIC per axis.
  logic cw_v, ch_v;
  logic signed [CV_W-1:0] xw, yw, xh, yh;
  axis_t bw, bh;

  ptz_cordic #(.TAG_W(AX_W)) u_cordic_w (
    .clk, .rst, .adv,
    .in_valid(zw_v && zh_v),
    .in_angle(ax_w.sat ? '0 : qw),
    .in_tag(ax_w),
    .out_valid(cw_v),
    .out_x(xw), .out_y(yw), .out_tag(bw)
  );

  ptz_cordic #(.TAG_W(AX_W)) u_cordic_h (
    .clk, .rst, .adv,
    .in_valid(zw_v && zh_v),
    .in_angle(ax_h.sat ? '0 : qh),
    .in_tag(ax_h),
    .out_valid(ch_v),
    .out_x(xh), .out_y(yh), .out_tag(bh)
  );

  // Stage C: one registered stage forms d*y and compares 2*d*y against range*x.
  typedef struct packed {
    logic lim;
    logic [ONUM_W-1:0] dy;
    logic [CV_W-2:0] x;
    axis_t ax;
  } mul_t;

  function automatic mul_t mul_in(input logic signed [CV_W-1:0] x,
                                  input logic signed [CV_W-1:0] y, input axis_t a,
                                  input logic [DIST_W-1:0] d);
    mul_t m;
    logic [CV_W-2:0] yp;
    logic [ONUM_W+1:0] lhs, rhs;
    yp = y[CV_W-1] ? '0 : y[CV_W-2:0];
    m.dy = ONUM_W'({14'd0, yp} * d);
    lhs = {m.dy, 1'b0};
    rhs = (ONUM_W+2)'(x[CV_W-2:0] * a.range);
    m.lim = a.sat || x[CV_W-1] || (x == '0) || (lhs >= rhs);
    m.x = x[CV_W-2:0];
    m.ax = a;
    return m;
  endfunction

  mul_t mw, mh;
  logic m_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= cw_v && ch_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mw <= mul_in(xw, yw, bw, d_eff);
      mh <= mul_in(xh, yh, bh, d_eff);
    end
  end

  // Stage D: offset division per axis.
  localparam int DTAG_W = $bits(mul_t);
  logic ow_v, oh_v;
  logic [ONUM_W-1:0] ow_q, oh_q;
  mul_t ow_t, oh_t;

  ptz_divider #(.NUM_W(ONUM_W), .DEN_W(CV_W-1), .TAG_W(DTAG_W)) u_div_ow (
    .clk, .rst, .adv,
    .in_valid(m_v),
    .in_num(mw.dy),
    .in_den(mw.lim ? (CV_W-1)'(1) : mw.x),
    .in_tag(mw),
    .out_valid(ow_v), .out_quo(ow_q), .out_tag(ow_t)
  );

  ptz_divider #(.NUM_W(ONUM_W), .DEN_W(CV_W-1), .TAG_W(DTAG_W)) u_div_oh (
    .clk, .rst, .adv,
    .in_valid(m_v),
    .in_num(mh.dy),
    .in_den(mh.lim ? (CV_W-1)'(1) : mh.x),
    .in_tag(mh),
    .out_valid(oh_v), .out_quo(oh_q), .out_tag(oh_t)
  );

  // Stage E: place the window and clamp it inside the frame.
  function automatic logic [POS_W-1:0] place(input mul_t t, input logic [ONUM_W-1:0] q,
                                             input logic [FRAME_W-1:0] full);
    logic [OFF_W-1:0] off;
    logic signed [FRAME_W+2:0] left, maxl;
    off = t.lim ? OFF_W'(t.ax.range >> 1) : OFF_W'(q);
    left = $signed({3'b0, full >> 1}) - $signed({3'b0, t.ax.crop >> 1});
    left = t.ax.neg ? left - $signed({3'b0, 1'b0, off}) : left + $signed({3'b0, 1'b0, off});
    maxl = $signed({3'b0, full}) - $signed({3'b0, t.ax.crop});
    if (left < 0) left = '0;
    if (left > maxl) left = maxl;
    return left[POS_W-1:0];
  endfunction

  logic [4*FRAME_W-3:0] out_data;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ow_v && oh_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= {place(ow_t, ow_q, w_eff), place(oh_t, oh_q, h_eff),
                   ow_t.ax.crop, oh_t.ax.crop};
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

`ifndef SYNTHESIS
  a_lanes_w: assert property (@(posedge clk) disable iff (rst) zw_v == zh_v)
    else $error("crop dividers out of step");
  a_lanes_c: assert property (@(posedge clk) disable iff (rst) cw_v == ch_v)
    else $error("cordic lanes out of step");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
`endif
endmodule

// ===== rtl/core/ptz_cordic.sv =====
// Unrolled pipelined CORDIC: one rotation step per stage, gives K*sin and K*cos.
module ptz_cordic #(
  parameter int TAG_W = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [ptz_pkg::CZ_W-1:0] in_angle,
  input  logic [TAG_W-1:0] in_tag,
  output logic out_valid,
  output logic signed [ptz_pkg::CV_W-1:0] out_x,
  output logic signed [ptz_pkg::CV_W-1:0] out_y,
  output logic [TAG_W-1:0] out_tag
);
  import ptz_pkg::*;

  logic signed [CV_W-1:0] x [CORDIC_STEPS+1];
  logic signed [CV_W-1:0] y [CORDIC_STEPS+1];
  logic signed [CZ_W:0] z [CORDIC_STEPS+1];
  logic [TAG_W-1:0] tag [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] vld;

  always_comb begin
    x[0] = CV_W'(64'sd1 << 30);
    y[0] = '0;
    z[0] = {1'b0, in_angle};
    tag[0] = in_tag;
    vld[0] = in_valid;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        tag[i+1] <= tag[i];
        if (!z[i][CZ_W]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - $signed({1'b0, atan_q28(i)});
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + $signed({1'b0, atan_q28(i)});
        end
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign out_x = x[CORDIC_STEPS];
  assign out_y = y[CORDIC_STEPS];
  assign out_tag = tag[CORDIC_STEPS];
endmodule

// ===== rtl/core/ptz_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ptz_divider #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 16,
  parameter int TAG_W = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic out_valid,
  output logic [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);
  logic [NUM_W-1:0] q [NUM_W+1];
  logic [DEN_W:0] r [NUM_W+1];
  logic [DEN_W-1:0] d [NUM_W+1];
  logic [TAG_W-1:0] tag [NUM_W+1];
  logic [NUM_W:0] vld;

  always_comb begin
    q[0] = in_num;
    r[0] = '0;
    d[0] = in_den;
    tag[0] = in_tag;
    vld[0] = in_valid;
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_bit
    logic [DEN_W+1:0] trial;
    assign trial = {r[i], q[i][NUM_W-1]} - {2'b00, d[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d[i+1] <= d[i];
        tag[i+1] <= tag[i];
        if (!trial[DEN_W+1]) begin
          r[i+1] <= trial[DEN_W:0];
          q[i+1] <= {q[i][NUM_W-2:0], 1'b1};
        end else begin
          r[i+1] <= {r[i][DEN_W-1:0], q[i][NUM_W-1]};
          q[i+1] <= {q[i][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign out_quo = q[NUM_W];
  assign out_tag = tag[NUM_W];
endmodule
